// ===== rtl/bfsk_modulator_nco_macros.svh =====
// Assertion macros shared by the modulator RTL.
`ifndef BFSK_MODULATOR_NCO_MACROS_SVH
`define BFSK_MODULATOR_NCO_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFSKM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bfskm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BFSKM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bfskm assertion failed");

`endif

// ===== rtl/bfskm_pkg.sv =====
// Package with the opcodes, register map and fixed constants of the modulator.
package bfskm_pkg;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_PUSH = 2'd1,
    OP_TAP  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    REG_SPB   = 3'd0,
    REG_BPW   = 3'd1,
    REG_PSTEP = 3'd2,
    REG_SSTEP = 3'd3,
    REG_AMP   = 3'd4,
    REG_TAPS  = 3'd5
  } reg_e;

  localparam int unsigned APB_AW = 5;

  localparam logic [15:0] SPB_RST = 16'd160;
  localparam logic [5:0]  BPW_RST = 6'd8;
  localparam logic [15:0] AMP_RST = 16'd32767;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

endpackage

// ===== rtl/bfskm_if.sv =====
// Valid/ready channel interfaces for the modulator input and result items.
interface bfskm_in_if #(
  parameter int WORD_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            operation;
  logic [WORD_WIDTH-1:0] data_word;
  logic [4:0]            tap_index;
  logic signed [15:0]    tap_value;

  modport source (output valid, operation, data_word, tap_index, tap_value, input ready);
  modport sink (input valid, operation, data_word, tap_index, tap_value, output ready);
endinterface

interface bfskm_out_if #(
  parameter int FILL_W = 7
);
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               bit_level;
  logic [FILL_W-1:0]  fifo_fill;
  logic               accepted;

  modport source (output valid, sample, bit_level, fifo_fill, accepted, input ready);
  modport sink (input valid, sample, bit_level, fifo_fill, accepted, output ready);
endinterface

// ===== rtl/bfskm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bfskm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== rtl/bfskm_sine_rom.sv =====
// Sine table ROM with registered read, contents built at elaboration.
module bfskm_sine_rom #(
  parameter int SINE_ENTRIES = 512
) (
  input  logic                            clk_i,
  input  logic [$clog2(SINE_ENTRIES)-1:0] addr_i,
  output logic signed [15:0]              data_o
);
  import bfskm_pkg::*;

  localparam logic [63:0] TAYLOR_DIV [5] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110};

  function automatic logic signed [15:0] sine_entry(input int unsigned k);
    logic [63:0] t;
    logic [63:0] quad;
    logic [63:0] rem;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    t    = 64'(k) * 64'd4;
    quad = t / SINE_ENTRIES;
    rem  = t % SINE_ENTRIES;
    if (quad[0]) begin
      rem = 64'(SINE_ENTRIES) - rem;
    end
    x    = (HALF_PI_Q30 * rem) / SINE_ENTRIES;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 5; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 64'sd16384) >>> 15;
    if (sum > 32767) begin
      sum = 32767;
    end
    return (quad >= 64'd2) ? 16'(-sum) : 16'(sum);
  endfunction

  logic signed [15:0] rom_w [SINE_ENTRIES];
  logic signed [15:0] data_q;

  for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_rom
    assign rom_w[g] = sine_entry(g);
  end

  always_ff @(posedge clk_i) begin
    data_q <= rom_w[addr_i];
  end

  assign data_o = data_q;
endmodule

// ===== rtl/bfsk_modulator_nco.sv =====
// Top level of the binary FSK modulator with FIR bit shaping and sine NCO.
//
//  Channel  Dir  Handshake                  Payload
//  in_i     in   valid/ready                operation, data_word, tap_index, tap_value
//  out_o    out  valid/ready                sample, bit_level, fifo_fill, accepted
//  APB      in   psel/penable/pwrite/pready six configuration registers
//
// A push, tap write or unused item goes to S_FIN; its result is registered when out_o
// is free. A tick runs S_TICK, with taps the filter walk (S_FRD, S_FACC per tap) and
// S_MUL, then S_PHASE to S_SAT. Words come from a FIFO memory, the sine from a ROM
// read at two addresses in turn. Reset clears all control state at once; unwritten
// taps read as zero. A stalled result holds the block before it starts the next
// item's result, and one new item is taken per result slot.
module bfsk_modulator_nco #(
  parameter int FIFO_DEPTH   = 64,
  parameter int WORD_WIDTH   = 32,
  parameter int MAX_TAPS     = 32,
  parameter int SINE_ENTRIES = 512
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  bfskm_in_if.sink                     in_i,
  bfskm_out_if.source                  out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bfskm_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import bfskm_pkg::*;

  `include "bfsk_modulator_nco_macros.svh"

  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int PTR_W   = FIFO_AW + 1;
  localparam int PTR2    = 2 * FIFO_DEPTH;
  localparam int FILL_W  = $clog2(FIFO_DEPTH + 1);
  localparam int TAP_AW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TAPK_W  = $clog2(MAX_TAPS + 1);
  localparam int LEVEL_W = 16 + TAPK_W;
  localparam int PROD_W  = LEVEL_W + 32;
  localparam int ROM_AW  = $clog2(SINE_ENTRIES);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_TICK  = 14'b00000000000010,
    S_FRD   = 14'b00000000000100,
    S_FACC  = 14'b00000000001000,
    S_MUL   = 14'b00000000010000,
    S_PHASE = 14'b00000000100000,
    S_IDX   = 14'b00000001000000,
    S_ROMA  = 14'b00000010000000,
    S_ROMB  = 14'b00000100000000,
    S_INT1  = 14'b00001000000000,
    S_INT2  = 14'b00010000000000,
    S_SCALE = 14'b00100000000000,
    S_SAT   = 14'b01000000000000,
    S_FIN   = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  logic [15:0]        spb_q, spb_d;
  logic [5:0]         bpw_q, bpw_d;
  logic [31:0]        pstep_q, pstep_d;
  logic signed [31:0] sstep_q, sstep_d;
  logic [15:0]        amp_q, amp_d;
  logic [5:0]         tcnt_q, tcnt_d;

  logic [PTR_W-1:0]      wp_q, wp_d, rp_q, rp_d;
  logic [WORD_WIDTH-1:0] shw_q, shw_d;
  logic [5:0]            bsent_q, bsent_d;
  logic [15:0]           scnt_q, scnt_d;
  logic                  cbit_q, cbit_d;
  logic [MAX_TAPS-1:0]   hist_q, hist_d;
  logic [TAP_AW-1:0]     hp_q, hp_d;
  logic [MAX_TAPS-1:0]   tvld_q, tvld_d;
  logic [31:0]           phase_q, phase_d;

  logic                      tick_q, tick_d, accp_q, accp_d;
  logic [TAPK_W-1:0]         k_q, k_d;
  logic                      trv_q;
  logic signed [LEVEL_W-1:0] level_q, level_d;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic [ROM_AW+31:0]        pm_q, pm_d;
  logic signed [15:0]        a_q, a_d, b_q, b_d;
  logic signed [33:0]        mul_q, mul_d;
  logic signed [34:0]        acc_q, acc_d;
  logic signed [35:0]        scl_q, scl_d;
  logic signed [15:0]        smp_q, smp_d;

  logic                  out_vld_q, out_vld_d;
  logic signed [15:0]    out_smp_q, out_smp_d;
  logic                  out_bit_q, out_bit_d;
  logic [FILL_W-1:0]     out_fill_q, out_fill_d;
  logic                  out_acc_q, out_acc_d;

  logic                  in_fire;
  op_e                   in_op;
  logic [PTR_W:0]        diff_w;
  logic [FILL_W-1:0]     fill_w;
  logic [FIFO_AW-1:0]    widx_w, ridx_w;
  logic                  fifo_we;
  logic [WORD_WIDTH-1:0] fifo_rdata;
  logic                  tap_we;
  logic [TAP_AW-1:0]     tap_waddr, tap_raddr;
  logic signed [15:0]    tap_rdata;
  logic [TAPK_W-1:0]     taps_w;
  logic [TAP_AW:0]       hsum_w;
  logic [TAP_AW-1:0]     hidx_w;
  logic [ROM_AW-1:0]     idx_w, nidx_w, rom_addr;
  logic signed [15:0]    rom_data;
  logic [15:0]           frac_w;
  logic signed [PROD_W-1:0] rnd_w;
  logic signed [35:0]    isum_w;
  logic signed [18:0]    interp_w;
  logic signed [36:0]    ssum_w;
  logic signed [21:0]    sres_w;
  logic                  cfg_we;
  reg_e                  cfg_idx;

  assign in_fire = in_i.valid && in_i.ready;
  assign in_op   = op_e'(in_i.operation);
  assign in_i.ready = (state_q == S_IDLE);

  assign diff_w = {1'b0, wp_q} - {1'b0, rp_q};
  assign fill_w = diff_w[PTR_W] ? FILL_W'(diff_w + (PTR_W+1)'(PTR2)) : FILL_W'(diff_w);
  assign widx_w = (wp_q >= PTR_W'(FIFO_DEPTH)) ? FIFO_AW'(wp_q - PTR_W'(FIFO_DEPTH))
                                                : FIFO_AW'(wp_q);
  assign ridx_w = (rp_q >= PTR_W'(FIFO_DEPTH)) ? FIFO_AW'(rp_q - PTR_W'(FIFO_DEPTH))
                                                : FIFO_AW'(rp_q);

  assign fifo_we   = in_fire && (in_op == OP_PUSH) && (fill_w < FILL_W'(FIFO_DEPTH));
  assign tap_we    = in_fire && (in_op == OP_TAP) && (32'(in_i.tap_index) < 32'(MAX_TAPS));
  assign tap_waddr = TAP_AW'(in_i.tap_index);
  assign tap_raddr = k_q[TAP_AW-1:0];

  assign taps_w = (32'(tcnt_q) > 32'(MAX_TAPS)) ? TAPK_W'(MAX_TAPS) : TAPK_W'(tcnt_q);
  assign hsum_w = {1'b0, hp_q} + (TAP_AW+1)'(MAX_TAPS) - (TAP_AW+1)'(k_q);
  assign hidx_w = (hsum_w >= (TAP_AW+1)'(MAX_TAPS)) ? TAP_AW'(hsum_w - (TAP_AW+1)'(MAX_TAPS))
                                                    : TAP_AW'(hsum_w);

  assign idx_w  = pm_q[32 +: ROM_AW];
  assign nidx_w = (32'(idx_w) == 32'(SINE_ENTRIES - 1)) ? '0 : idx_w + 1'b1;
  assign frac_w = pm_q[31:16];
  assign rom_addr = (state_q == S_ROMB) ? nidx_w : idx_w;

  assign rnd_w    = (prod_q + PROD_W'(16384)) >>> 15;
  assign isum_w   = 36'(acc_q) + 36'sd32768;
  assign interp_w = isum_w[34:16];
  assign ssum_w   = 37'(scl_q) + 37'sd16384;
  assign sres_w   = ssum_w[36:15];

  bfskm_ram #(.WIDTH(WORD_WIDTH), .DEPTH(FIFO_DEPTH)) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (fifo_we),
    .waddr_i (widx_w),
    .wdata_i (in_i.data_word),
    .raddr_i (ridx_w),
    .rdata_o (fifo_rdata)
  );

  bfskm_ram #(.WIDTH(16), .DEPTH(MAX_TAPS)) u_tap_ram (
    .clk_i   (clk_i),
    .we_i    (tap_we),
    .waddr_i (tap_waddr),
    .wdata_i (in_i.tap_value),
    .raddr_i (tap_raddr),
    .rdata_o (tap_rdata)
  );

  bfskm_sine_rom #(.SINE_ENTRIES(SINE_ENTRIES)) u_sine_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_e'(paddr[4:2]);
  assign pready  = 1'b1;

  always_comb begin
    case (cfg_idx)
      REG_SPB:   prdata = 32'(spb_q);
      REG_BPW:   prdata = 32'(bpw_q);
      REG_PSTEP: prdata = pstep_q;
      REG_SSTEP: prdata = sstep_q;
      REG_AMP:   prdata = 32'(amp_q);
      REG_TAPS:  prdata = 32'(tcnt_q);
      default:   prdata = '0;
    endcase
  end

  always_comb begin
    spb_d   = spb_q;
    bpw_d   = bpw_q;
    pstep_d = pstep_q;
    sstep_d = sstep_q;
    amp_d   = amp_q;
    tcnt_d  = tcnt_q;
    if (cfg_we) begin
      case (cfg_idx)
        REG_SPB:   spb_d   = pwdata[15:0];
        REG_BPW:   bpw_d   = pwdata[5:0];
        REG_PSTEP: pstep_d = pwdata;
        REG_SSTEP: sstep_d = pwdata;
        REG_AMP:   amp_d   = pwdata[15:0];
        REG_TAPS:  tcnt_d  = pwdata[5:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    state_d    = state_q;
    wp_d       = wp_q;
    rp_d       = rp_q;
    shw_d      = shw_q;
    bsent_d    = bsent_q;
    scnt_d     = scnt_q;
    cbit_d     = cbit_q;
    hist_d     = hist_q;
    hp_d       = hp_q;
    tvld_d     = tvld_q;
    phase_d    = phase_q;
    tick_d     = tick_q;
    accp_d     = accp_q;
    k_d        = k_q;
    level_d    = level_q;
    prod_d     = prod_q;
    pm_d       = pm_q;
    a_d        = a_q;
    b_d        = b_q;
    mul_d      = mul_q;
    acc_d      = acc_q;
    scl_d      = scl_q;
    smp_d      = smp_q;
    out_vld_d  = out_vld_q && !out_o.ready;
    out_smp_d  = out_smp_q;
    out_bit_d  = out_bit_q;
    out_fill_d = out_fill_q;
    out_acc_d  = out_acc_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          tick_d = (in_op == OP_TICK);
          accp_d = fifo_we;
          if (fifo_we) begin
            wp_d = (wp_q == PTR_W'(PTR2 - 1)) ? '0 : wp_q + 1'b1;
          end
          if (tap_we) begin
            tvld_d[tap_waddr] = 1'b1;
          end
          state_d = (in_op == OP_TICK) ? S_TICK : S_FIN;
        end
      end
      S_TICK: begin
        scnt_d = scnt_q + 1'b1;
        if (scnt_d >= spb_q) begin
          scnt_d = '0;
          if (bsent_q < bpw_q) begin
            cbit_d  = shw_q[0];
            shw_d   = shw_q >> 1;
            bsent_d = bsent_q + 1'b1;
          end else if (fill_w != '0) begin
            rp_d    = (rp_q == PTR_W'(PTR2 - 1)) ? '0 : rp_q + 1'b1;
            cbit_d  = fifo_rdata[0];
            shw_d   = fifo_rdata >> 1;
            bsent_d = 6'd1;
          end else begin
            cbit_d = 1'b1;
          end
        end
        hp_d = (32'(hp_q) == MAX_TAPS - 1) ? '0 : hp_q + 1'b1;
        hist_d[hp_d] = cbit_d;
        k_d     = '0;
        level_d = '0;
        state_d = (taps_w == '0) ? S_PHASE : S_FRD;
      end
      S_FRD: begin
        state_d = S_FACC;
      end
      S_FACC: begin
        if (hist_q[hidx_w] && trv_q) begin
          level_d = level_q + LEVEL_W'(tap_rdata);
        end
        k_d     = k_q + 1'b1;
        state_d = (k_d == taps_w) ? S_MUL : S_FRD;
      end
      S_MUL: begin
        prod_d  = PROD_W'(level_q) * PROD_W'(sstep_q);
        state_d = S_PHASE;
      end
      S_PHASE: begin
        if (taps_w == '0) begin
          phase_d = phase_q + pstep_q + (cbit_q ? sstep_q : 32'd0);
        end else begin
          phase_d = phase_q + pstep_q + rnd_w[31:0];
        end
        state_d = S_IDX;
      end
      S_IDX: begin
        pm_d    = (ROM_AW+32)'(phase_q) * (ROM_AW+32)'(SINE_ENTRIES);
        state_d = S_ROMA;
      end
      S_ROMA: begin
        state_d = S_ROMB;
      end
      S_ROMB: begin
        a_d     = rom_data;
        state_d = S_INT1;
      end
      S_INT1: begin
        b_d     = rom_data;
        mul_d   = 34'(a_q) * $signed({1'b0, 17'd65536 - 17'(frac_w)});
        state_d = S_INT2;
      end
      S_INT2: begin
        acc_d   = 35'(mul_q) + 35'(b_q) * 35'($signed({1'b0, frac_w}));
        state_d = S_SCALE;
      end
      S_SCALE: begin
        scl_d   = 36'(interp_w) * $signed({1'b0, amp_q});
        state_d = S_SAT;
      end
      S_SAT: begin
        if (sres_w > 22'sd32767) begin
          smp_d = 16'sh7fff;
        end else if (sres_w < -22'sd32768) begin
          smp_d = 16'sh8000;
        end else begin
          smp_d = sres_w[15:0];
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d  = 1'b1;
          out_smp_d  = tick_q ? smp_q : 16'sd0;
          out_bit_d  = cbit_q;
          out_fill_d = fill_w;
          out_acc_d  = accp_q;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      spb_q     <= SPB_RST;
      bpw_q     <= BPW_RST;
      pstep_q   <= '0;
      sstep_q   <= '0;
      amp_q     <= AMP_RST;
      tcnt_q    <= '0;
      wp_q      <= '0;
      rp_q      <= '0;
      shw_q     <= '0;
      bsent_q   <= BPW_RST;
      scnt_q    <= '0;
      cbit_q    <= 1'b1;
      hist_q    <= '0;
      hp_q      <= '0;
      tvld_q    <= '0;
      phase_q   <= '0;
      tick_q    <= 1'b0;
      accp_q    <= 1'b0;
      k_q       <= '0;
      trv_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      spb_q     <= spb_d;
      bpw_q     <= bpw_d;
      pstep_q   <= pstep_d;
      sstep_q   <= sstep_d;
      amp_q     <= amp_d;
      tcnt_q    <= tcnt_d;
      wp_q      <= wp_d;
      rp_q      <= rp_d;
      shw_q     <= shw_d;
      bsent_q   <= bsent_d;
      scnt_q    <= scnt_d;
      cbit_q    <= cbit_d;
      hist_q    <= hist_d;
      hp_q      <= hp_d;
      tvld_q    <= tvld_d;
      phase_q   <= phase_d;
      tick_q    <= tick_d;
      accp_q    <= accp_d;
      k_q       <= k_d;
      trv_q     <= tvld_q[tap_raddr];
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q    <= level_d;
    prod_q     <= prod_d;
    pm_q       <= pm_d;
    a_q        <= a_d;
    b_q        <= b_d;
    mul_q      <= mul_d;
    acc_q      <= acc_d;
    scl_q      <= scl_d;
    smp_q      <= smp_d;
    out_smp_q  <= out_smp_d;
    out_bit_q  <= out_bit_d;
    out_fill_q <= out_fill_d;
    out_acc_q  <= out_acc_d;
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.sample    = out_smp_q;
  assign out_o.bit_level = out_bit_q;
  assign out_o.fifo_fill = out_fill_q;
  assign out_o.accepted  = out_acc_q;

  `BFSKM_ASSERT_IMPLY(a_fill_bound, clk_i, rst_ni, 1'b1, fill_w <= FILL_W'(FIFO_DEPTH))
  `BFSKM_ASSERT_NEXT(a_push_adv, clk_i, rst_ni, fifo_we, wp_q != $past(wp_q))
  `BFSKM_ASSERT_IMPLY(a_acc_zero, clk_i, rst_ni, out_vld_q && out_acc_q, out_smp_q == 16'sd0)
  `BFSKM_ASSERT_NEXT(a_rp_tick, clk_i, rst_ni, state_q != S_TICK, rp_q == $past(rp_q))

endmodule
